/* hdl/tsf_pkg.sv */
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the touch sample filter
// Request, report and mode codes, field widths and reset values.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int LIMIT_W         = 10;
  localparam int REQ_W           = 2;
  localparam int CODE_W          = 2;
  localparam int NUM_CELLS       = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  typedef enum logic [REQ_W-1:0] {
    REQ_PEN  = 2'd0,
    REQ_CONV = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [CODE_W-1:0] {
    KIND_NONE     = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_POSITION = 2'd2
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    MODE_WAIT_DOWN = 2'd0,
    MODE_MEASURE   = 2'd1,
    MODE_WAIT_UP   = 2'd2
  } mode_t;

endpackage

/* hdl/touch_sample_filter_fsm_core.sv */
// ----------------------------------------------------------------------------
// touch_sample_filter_fsm_core: four-sample jitter filter for a touch panel
// Takes pen, conversion and tick events, collects bursts of four sample pairs
// in a shift line of cells, checks jitter and reports release or position.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                         | Flow
//  --------+-------------------------------------------------+-----------
//  in      | in_valid, in_stall, req_type, pen_up,           | valid/stall
//          | x_sample, y_sample                              |
//  out     | out_valid, out_stall, report_kind, next_mode,   | valid/stall
//          | x_pos, y_pos                                    |
//  cfg     | cfg_valid, cfg_ready, cfg_data (jitter_limit)   | valid/ready
//
//  One event beat per cycle while in_stall is low; each beat yields one
//  result beat in the cycle after, from the output register. The jitter test
//  and mean work in the accepting cycle on three cells plus the incoming pair.
//  Reset (rst, synchronous) clears the sample count, the output valid and
//  sets jitter_limit to 10; cell contents are not reset.
//  in_stall rises only while a result waits and out_stall is high.
//
module touch_sample_filter_fsm_core
  import tsf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // event channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [REQ_W-1:0]       req_type,
  input  logic                   pen_up,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CODE_W-1:0]      report_kind,
  output logic [CODE_W-1:0]      next_mode,
  output logic [SAMPLE_BITS-1:0] x_pos,
  output logic [SAMPLE_BITS-1:0] y_pos,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LIMIT_W-1:0]     cfg_data
);

  // configuration register
  logic [LIMIT_W-1:0] jitter_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      jitter_limit <= cfg_data;
    end
  end

  // handshake: the output register takes a new beat when empty or draining
  logic in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // decode the event
  logic conv_beat;
  logic [1:0] sample_count;
  logic [1:0] sample_count_next;

  assign conv_beat = in_accept && !pen_up && (req_t'(req_type) == REQ_CONV);

  // shift line of cells: after three conversions tap 3 holds sample 0,
  // tap 2 sample 1 and tap 1 sample 2; the incoming pair on tap 0 is sample 3
  logic [SAMPLE_BITS-1:0] x_tap [NUM_CELLS+1];
  logic [SAMPLE_BITS-1:0] y_tap [NUM_CELLS+1];

  assign x_tap[0] = x_sample;
  assign y_tap[0] = y_sample;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tsf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .shift_en(conv_beat),
      .x_in    (x_tap[i]),
      .y_in    (y_tap[i]),
      .x_out   (x_tap[i+1]),
      .y_out   (y_tap[i+1])
    );
  end

  logic                   pass;
  logic [SAMPLE_BITS-1:0] x_avg;
  logic [SAMPLE_BITS-1:0] y_avg;

  tsf_check #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .x0   (x_tap[3]),
    .x1   (x_tap[2]),
    .x2   (x_tap[1]),
    .x3   (x_tap[0]),
    .y0   (y_tap[3]),
    .y1   (y_tap[2]),
    .y2   (y_tap[1]),
    .y3   (y_tap[0]),
    .limit(jitter_limit),
    .pass (pass),
    .x_avg(x_avg),
    .y_avg(y_avg)
  );

  // result of this beat
  kind_t                  kind_next;
  mode_t                  mode_next;
  logic [SAMPLE_BITS-1:0] x_pos_next;
  logic [SAMPLE_BITS-1:0] y_pos_next;

  always_comb begin
    kind_next         = KIND_NONE;
    mode_next         = MODE_MEASURE;
    x_pos_next        = '0;
    y_pos_next        = '0;
    sample_count_next = sample_count;
    if (pen_up) begin
      // release: drop any partial burst
      kind_next         = KIND_RELEASE;
      mode_next         = MODE_WAIT_DOWN;
      sample_count_next = 2'd0;
    end else if (req_t'(req_type) == REQ_CONV) begin
      if (sample_count == 2'd3) begin
        if (pass) begin
          kind_next  = KIND_POSITION;
          x_pos_next = x_avg;
          y_pos_next = y_avg;
        end
        mode_next         = MODE_WAIT_UP;
        sample_count_next = 2'd0;
      end else begin
        sample_count_next = sample_count + 2'd1;
      end
    end
  end

  // sample count advances only on accepted beats
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= 2'd0;
    end else if (in_accept) begin
      sample_count <= sample_count_next;
    end
  end

  // output register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      report_kind <= kind_next;
      next_mode   <= mode_next;
      x_pos       <= x_pos_next;
      y_pos       <= y_pos_next;
    end
  end

endmodule

/* hdl/tsf_cell.sv */
// ----------------------------------------------------------------------------
// tsf_cell: one stage of the sample shift line
// Holds one X/Y sample pair and passes it on to the next cell when enabled.
// ----------------------------------------------------------------------------
module tsf_cell
  import tsf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [SAMPLE_BITS-1:0] x_in,
  input  logic [SAMPLE_BITS-1:0] y_in,
  output logic [SAMPLE_BITS-1:0] x_out,
  output logic [SAMPLE_BITS-1:0] y_out
);

  logic [SAMPLE_BITS-1:0] x_hold;
  logic [SAMPLE_BITS-1:0] y_hold;

  // capture the neighbour's pair on each conversion beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_hold <= x_in;
      y_hold <= y_in;
    end
  end

  assign x_out = x_hold;
  assign y_out = y_hold;

endmodule

/* hdl/tsf_check.sv */
// ----------------------------------------------------------------------------
// tsf_check: jitter test and four-sample mean
// Checks samples 2 and 3 against the mean of their two predecessors on both
// axes and forms the truncated average of all four.
// ----------------------------------------------------------------------------
module tsf_check
  import tsf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] x0,
  input  logic [SAMPLE_BITS-1:0] x1,
  input  logic [SAMPLE_BITS-1:0] x2,
  input  logic [SAMPLE_BITS-1:0] x3,
  input  logic [SAMPLE_BITS-1:0] y0,
  input  logic [SAMPLE_BITS-1:0] y1,
  input  logic [SAMPLE_BITS-1:0] y2,
  input  logic [SAMPLE_BITS-1:0] y3,
  input  logic [LIMIT_W-1:0]     limit,
  output logic                   pass,
  output logic [SAMPLE_BITS-1:0] x_avg,
  output logic [SAMPLE_BITS-1:0] y_avg
);

  localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

  function automatic logic near(input logic [SAMPLE_BITS-1:0] p0,
                                input logic [SAMPLE_BITS-1:0] p1,
                                input logic [SAMPLE_BITS-1:0] s,
                                input logic [LIMIT_W-1:0]     lim);
    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] diff;
    sum  = {1'b0, p0} + {1'b0, p1};
    mean = sum[SAMPLE_BITS:1];
    diff = (s > mean) ? (s - mean) : (mean - s);
    return CMP_W'(diff) <= CMP_W'(lim);
  endfunction

  logic [SAMPLE_BITS+1:0] x_sum;
  logic [SAMPLE_BITS+1:0] y_sum;

  assign pass = near(x0, x1, x2, limit) && near(y0, y1, y2, limit) &&
                near(x1, x2, x3, limit) && near(y1, y2, y3, limit);

  assign x_sum = (SAMPLE_BITS+2)'(x0) + (SAMPLE_BITS+2)'(x1) +
                 (SAMPLE_BITS+2)'(x2) + (SAMPLE_BITS+2)'(x3);
  assign y_sum = (SAMPLE_BITS+2)'(y0) + (SAMPLE_BITS+2)'(y1) +
                 (SAMPLE_BITS+2)'(y2) + (SAMPLE_BITS+2)'(y3);

  // drop the two low bits: truncated mean of four
  assign x_avg = x_sum[SAMPLE_BITS+1:2];
  assign y_avg = y_sum[SAMPLE_BITS+1:2];

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the touch sample filter
// Drives pen, conversion and tick events in bursts with random gaps. A
// receiver stalls on its own shifting pattern. Every event is run through a
// bench-side copy of the four-sample jitter filter, and each result beat is
// checked field by field. The jitter limit is reprogrammed between phases,
// including both ends of its range.
// ----------------------------------------------------------------------------
module tb_top
  import tsf_pkg::*;
();

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int PHASE_ITEMS = 275;

  typedef struct {
    req_t          req;
    logic          up;
    logic [SB-1:0] x;
    logic [SB-1:0] y;
  } touch_event_t;

  typedef struct {
    kind_t         kind;
    mode_t         mode;
    logic [SB-1:0] x;
    logic [SB-1:0] y;
  } touch_report_t;

  // Drive every input to a known value from time zero.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [REQ_W-1:0]   req_type  = '0;
  logic               pen_up    = 1'b0;
  logic [SB-1:0]      x_sample  = '0;
  logic [SB-1:0]      y_sample  = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [LIMIT_W-1:0] cfg_data  = '0;
  logic               in_stall;
  logic               out_valid;
  logic               cfg_ready;
  logic [CODE_W-1:0]  report_kind;
  logic [CODE_W-1:0]  next_mode;
  logic [SB-1:0]      x_pos;
  logic [SB-1:0]      y_pos;

  // Bench-side filter state: burst position, held sample pairs, limit.
  int unsigned   burst_cnt;
  int unsigned   x_hist[4];
  int unsigned   y_hist[4];
  int unsigned   jitter_lim;

  touch_event_t  event_queue[$];
  touch_report_t pending_reports[$];
  touch_event_t  bus_ev;
  touch_report_t exp_rep;
  int            n_err;

  // Sender pacing and receiver stall pattern.
  int            burst_left;
  int            gap_left;
  logic          drv_valid;
  int            stall_mode;
  int            stall_left;
  int            cyc;
  logic          stall_nxt;

  always #10 clk = ~clk;

  touch_sample_filter_fsm_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .pen_up      (pen_up),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .report_kind (report_kind),
    .next_mode   (next_mode),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Filter prediction
  // --------------------------------------------------------------------------

  // A sample passes if it lies within the limit of the truncated mean of its
  // two predecessors.
  function automatic bit within_limit(int unsigned a, int unsigned b, int unsigned s);
    int unsigned mean;
    int unsigned diff;
    mean = (a + b) >> 1;
    diff = (s > mean) ? s - mean : mean - s;
    return diff <= jitter_lim;
  endfunction

  // Advance the filter by one event and return the report it causes.
  function automatic touch_report_t filter_step(touch_event_t ev);
    touch_report_t r;
    int unsigned   idx;
    r.kind = KIND_NONE;
    r.mode = MODE_MEASURE;
    r.x    = '0;
    r.y    = '0;
    if (ev.up) begin
      // Lift of the pen on any event: release, and restart the burst.
      burst_cnt = 0;
      r.kind    = KIND_RELEASE;
      r.mode    = MODE_WAIT_DOWN;
    end else if (ev.req == REQ_CONV) begin
      idx         = burst_cnt;
      x_hist[idx] = ev.x;
      y_hist[idx] = ev.y;
      if (idx == 3) begin
        // Fourth pair: jitter test on both axes, then average on a pass.
        if (within_limit(x_hist[0], x_hist[1], x_hist[2]) &&
            within_limit(y_hist[0], y_hist[1], y_hist[2]) &&
            within_limit(x_hist[1], x_hist[2], x_hist[3]) &&
            within_limit(y_hist[1], y_hist[2], y_hist[3])) begin
          r.kind = KIND_POSITION;
          r.x    = SB'((x_hist[0] + x_hist[1] + x_hist[2] + x_hist[3]) >> 2);
          r.y    = SB'((y_hist[0] + y_hist[1] + y_hist[2] + y_hist[3]) >> 2);
        end
        burst_cnt = 0;
        r.mode    = MODE_WAIT_UP;
      end else begin
        burst_cnt = idx + 1;
      end
    end
    // Pen, tick and the unused request code with the pen down: measure.
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_ev(req_t r, logic up, int x, int y);
    touch_event_t ev;
    ev.req = r;
    ev.up  = up;
    ev.x   = SB'(x);
    ev.y   = SB'(y);
    event_queue.push_back(ev);
  endfunction

  // Pick a sample within d of base, clipped to the sample range.
  function automatic int near(int base, int d);
    int v;
    v = base + int'($urandom_range(0, 2 * d)) - d;
    if (v < 0) v = 0;
    if (v > (1 << SB) - 1) v = (1 << SB) - 1;
    return v;
  endfunction

  // Any request code but a conversion.
  function automatic req_t idle_req();
    req_t r;
    r = req_t'($urandom_range(0, 3));
    if (r == REQ_CONV) r = REQ_TICK;
    return r;
  endfunction

  // Queue one random sequence and return the number of events queued.
  // Mostly well-formed touches with random jitter, then broken bursts and
  // plain noise.
  function automatic int queue_sequence(int lim);
    int sel, n, bx, by, d, k;
    n   = 0;
    sel = $urandom_range(0, 99);
    bx  = $urandom_range(0, (1 << SB) - 1);
    by  = $urandom_range(0, (1 << SB) - 1);
    if (sel < 70) begin
      if ($urandom_range(0, 1)) begin
        push_ev(idle_req(), 1'b0, $urandom, $urandom);
        n++;
      end
      // Spread mostly inside the limit, sometimes at it or just past it.
      k = $urandom_range(0, 9);
      d = (k < 6) ? lim / 2 : (k < 9) ? lim : lim + $urandom_range(1, 20);
      repeat (4) begin
        push_ev(REQ_CONV, 1'b0, near(bx, d), near(by, d));
        n++;
      end
      push_ev(idle_req(), logic'($urandom_range(0, 1)), $urandom, $urandom);
      n++;
    end else if (sel < 85) begin
      // Lift the pen part-way through a burst.
      k = $urandom_range(1, 3);
      repeat (k) begin
        push_ev(REQ_CONV, 1'b0, near(bx, lim), near(by, lim));
        n++;
      end
      push_ev(req_t'($urandom_range(0, 3)), 1'b1, $urandom, $urandom);
      n++;
    end else begin
      k = $urandom_range(1, 4);
      repeat (k) begin
        push_ev(req_t'($urandom_range(0, 3)), logic'($urandom_range(0, 1)),
                $urandom, $urandom);
        n++;
      end
    end
    return n;
  endfunction

  // Hold until every queued event has gone in and every report has come out.
  task automatic drain();
    do @(negedge clk);
    while (event_queue.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    jitter_lim = v;
  endtask

  // --------------------------------------------------------------------------
  // Event driver: take a beat from the queue whenever the bus is free, in
  // bursts of random length with random gaps between them.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      // A beat accepted at this edge advances the filter model.
      if (in_valid && !in_stall) pending_reports.push_back(filter_step(bus_ev));
      // Hold the payload while stalled; otherwise present the next beat.
      if (!in_valid || !in_stall) begin
        drv_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (event_queue.size() != 0) begin
          bus_ev   = event_queue.pop_front();
          req_type <= bus_ev.req;
          pen_up   <= bus_ev.up;
          x_sample <= bus_ev.x;
          y_sample <= bus_ev.y;
          drv_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= drv_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted beat against the oldest prediction,
  // and stall on a pattern that switches between randomly chosen modes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
      cyc        = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result beat with no event outstanding");
          n_err++;
        end else begin
          exp_rep = pending_reports.pop_front();
          if (report_kind !== exp_rep.kind) begin
            $error("report_kind: expected %0d, got %0d", exp_rep.kind, report_kind);
            n_err++;
          end
          if (next_mode !== exp_rep.mode) begin
            $error("next_mode: expected %0d, got %0d", exp_rep.mode, next_mode);
            n_err++;
          end
          if (x_pos !== exp_rep.x) begin
            $error("x_pos: expected %0d, got %0d", exp_rep.x, x_pos);
            n_err++;
          end
          if (y_pos !== exp_rep.y) begin
            $error("y_pos: expected %0d, got %0d", exp_rep.y, y_pos);
            n_err++;
          end
        end
      end
      cyc++;
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: stall_nxt = 1'b0;
        1: stall_nxt = ($urandom_range(0, 3) == 0);
        2: stall_nxt = ($urandom_range(0, 2) != 0);
        default: stall_nxt = ((cyc % 5) < 2);
      endcase
      out_stall <= stall_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed events at the reset limit, then random phases
  // with the limit reprogrammed in between.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned lim_set[$];
    int          n;
    n_err      = 0;
    burst_cnt  = 0;
    jitter_lim = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Release on a pen event, then measure with the pen down.
    push_ev(REQ_PEN, 1'b1, 0, 0);
    push_ev(REQ_PEN, 1'b0, 0, 0);
    // Bursts at both ends of the sample range.
    repeat (4) push_ev(REQ_CONV, 1'b0, 0, 0);
    repeat (4) push_ev(REQ_CONV, 1'b0, 1023, 1023);
    // Failed jitter check: third X sample one past the limit.
    push_ev(REQ_CONV, 1'b0, 100, 500);
    push_ev(REQ_CONV, 1'b0, 100, 500);
    push_ev(REQ_CONV, 1'b0, 111, 500);
    push_ev(REQ_CONV, 1'b0, 100, 500);
    // X exactly at the limit on both checks; Y fails on the fourth sample.
    push_ev(REQ_CONV, 1'b0, 100, 700);
    push_ev(REQ_CONV, 1'b0, 102, 700);
    push_ev(REQ_CONV, 1'b0, 111, 700);
    push_ev(REQ_CONV, 1'b0, 96, 689);
    // Pen lifted mid-burst on a conversion clears the count.
    push_ev(REQ_CONV, 1'b0, 300, 300);
    push_ev(REQ_CONV, 1'b0, 301, 301);
    push_ev(REQ_CONV, 1'b1, 1023, 0);
    // Unused request code, and ticks with the pen up and down.
    push_ev(REQ_NONE, 1'b0, 1023, 1023);
    push_ev(REQ_NONE, 1'b1, 0, 0);
    push_ev(REQ_TICK, 1'b1, 512, 512);
    push_ev(REQ_TICK, 1'b0, 512, 512);
    drain();

    // Limit settings: both extremes, the smallest non-zero, and a few others.
    lim_set = '{0, 1023, 1, $urandom_range(2, 40), $urandom_range(2, 40),
                $urandom_range(41, 1022)};
    foreach (lim_set[i]) begin
      write_limit(LIMIT_W'(lim_set[i]));
      @(negedge clk);
      n = 0;
      while (n < PHASE_ITEMS) n += queue_sequence(lim_set[i]);
      drain();
    end

    repeat (4) @(posedge clk);
    if (n_err == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* touch_sample_filter_fsm_core.f */
hdl/tsf_pkg.sv
hdl/tsf_cell.sv
hdl/tsf_check.sv
hdl/touch_sample_filter_fsm_core.sv
bench/tb_top.sv
